// ===== rtl/core/lrtf_pkg.sv =====
// Package for the longest-remaining-time-first tick scheduler.
// Holds the command and status codes and the structs passed between the slot cells.
// No dependencies.
package lrtf_pkg;

    localparam int TIME_W   = 32;
    localparam int VALUE_W  = 16;
    localparam int CMD_W    = 2;
    localparam int STATUS_W = 3;
    localparam int PID_W    = 4;
    localparam int IN_W     = 32;
    localparam int OUT_W    = 136;

    localparam logic [TIME_W-1:0] TIME_MAX = '1;

    localparam logic [CMD_W-1:0] CMD_ADD   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_TICK  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

    localparam logic [STATUS_W-1:0] ST_ADDED    = 3'd0;
    localparam logic [STATUS_W-1:0] ST_REJECTED = 3'd1;
    localparam logic [STATUS_W-1:0] ST_IDLE     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_RAN      = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FINISHED = 3'd4;
    localparam logic [STATUS_W-1:0] ST_CLEARED  = 3'd5;

    typedef struct packed {
        logic               found;
        logic [VALUE_W-1:0] rem;
        logic [VALUE_W-1:0] arr;
        logic [VALUE_W-1:0] burst;
        logic [TIME_W-1:0]  fs;
    } slot_tok_t;

    typedef struct packed {
        logic               en;
        logic [VALUE_W-1:0] arr;
        logic [VALUE_W-1:0] burst;
    } slot_wr_t;

    typedef struct packed {
        logic              en;
        logic              first;
        logic [TIME_W-1:0] t;
    } slot_upd_t;

endpackage

// ===== rtl/core/lrtf_cell.sv =====
// One slot cell of the scheduler chain: holds one process and passes the best candidate on.
// Depends on lrtf_pkg.
module lrtf_cell #(
    parameter int NUM_SLOTS = 16,
    parameter int CELL_ID   = 0,
    localparam int IDW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1,
    localparam int CW  = $clog2(NUM_SLOTS + 1)
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic [CW-1:0]                    count,
    input  logic [lrtf_pkg::TIME_W-1:0]      cur_time,
    input  lrtf_pkg::slot_wr_t               wr,
    input  logic [IDW-1:0]                   wr_id,
    input  lrtf_pkg::slot_upd_t              upd,
    input  logic [IDW-1:0]                   upd_id,
    input  lrtf_pkg::slot_tok_t              tok_in,
    input  logic [IDW-1:0]                   id_in,
    output lrtf_pkg::slot_tok_t              tok_out,
    output logic [IDW-1:0]                   id_out
);

    logic [lrtf_pkg::VALUE_W-1:0] arr_reg;
    logic [lrtf_pkg::VALUE_W-1:0] burst_reg;
    logic [lrtf_pkg::VALUE_W-1:0] rem_reg;
    logic [lrtf_pkg::TIME_W-1:0]  fs_reg;
    lrtf_pkg::slot_tok_t          tok_reg;
    lrtf_pkg::slot_tok_t          tok_next;
    logic [IDW-1:0]               id_reg;
    logic [IDW-1:0]               id_next;
    logic                         own_ok;
    logic                         take;

    always_comb
    begin
        own_ok = (CW'(CELL_ID) < count)
                 && ({{(lrtf_pkg::TIME_W-lrtf_pkg::VALUE_W){1'b0}}, arr_reg} <= cur_time)
                 && (rem_reg != '0);
        take = own_ok && (!tok_in.found || (rem_reg > tok_in.rem)
                          || ((rem_reg == tok_in.rem) && (arr_reg < tok_in.arr)));
        if (take)
        begin
            tok_next.found = 1'b1;
            tok_next.rem   = rem_reg;
            tok_next.arr   = arr_reg;
            tok_next.burst = burst_reg;
            tok_next.fs    = fs_reg;
            id_next        = IDW'(CELL_ID);
        end
        else
        begin
            tok_next = tok_in;
            id_next  = id_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg <= id_next;
        if (wr.en && (wr_id == IDW'(CELL_ID)))
        begin
            arr_reg   <= wr.arr;
            burst_reg <= wr.burst;
            rem_reg   <= wr.burst;
            fs_reg    <= '0;
        end
        else if (upd.en && (upd_id == IDW'(CELL_ID)))
        begin
            rem_reg <= rem_reg - lrtf_pkg::VALUE_W'(1);
            if (upd.first)
            begin
                fs_reg <= upd.t;
            end
        end
    end

    assign tok_out = tok_reg;
    assign id_out  = id_reg;

endmodule

// ===== rtl/core/lrtf_tick_scheduler_top.sv =====
// Top level of the longest-remaining-time-first tick scheduler: control, time and results.
// Depends on lrtf_pkg and lrtf_cell.
//
// Channel   Dir  tdata                                           tuser
// s_*       in   arrival_time[15:0], burst_time[31:16]           command[1:0]
// m_*       out  proc_id, completion, response, turnaround, wait status[2:0]
//
// An add, a clear or a rejected request goes from acceptance to the deliver state, which loads
// the output register once it is free or its result is being taken.
// A tick goes through the scan state, as the candidate travels one cell per cycle, then the
// serve state, the wait state when the process finishes, and the deliver state; its result
// reaches the output register from the deliver state.
// Reset clears the time, the process count and the control state; slot contents are not cleared.
// A new request is taken once the previous result sits in the output register.
module lrtf_tick_scheduler_top #(
    parameter int MAX_PROCESSES = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // arrival_time [15:0], burst_time [31:16]
    input  logic [lrtf_pkg::IN_W-1:0]      s_tdata,
    // command [1:0]
    input  logic [lrtf_pkg::CMD_W-1:0]     s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // proc_id [3:0], completion_time [35:4], response_time [67:36],
    // turnaround_time [99:68], waiting_time [131:100], zero [135:132]
    output logic [lrtf_pkg::OUT_W-1:0]     m_tdata,
    // status [2:0]
    output logic [lrtf_pkg::STATUS_W-1:0]  m_tuser
);

    localparam int IDW = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
    localparam int CW  = $clog2(MAX_PROCESSES + 1);
    localparam int TW  = lrtf_pkg::TIME_W;
    localparam int VW  = lrtf_pkg::VALUE_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SERVE,
        S_WAIT,
        S_DELIVER
    } state_t;

    state_t                          state_reg, state_next;
    logic [CW-1:0]                   count_reg, count_next;
    logic [TW-1:0]                   time_reg, time_next;
    logic [IDW-1:0]                  cnt_reg, cnt_next;
    logic                            m_valid_reg, m_valid_next;
    logic [lrtf_pkg::STATUS_W-1:0]   m_user_reg, m_user_next;
    logic [lrtf_pkg::OUT_W-1:0]      m_data_reg, m_data_next;
    logic [lrtf_pkg::STATUS_W-1:0]   res_status_reg, res_status_next;
    logic [lrtf_pkg::PID_W-1:0]      res_id_reg, res_id_next;
    logic [TW-1:0]                   res_comp_reg, res_comp_next;
    logic [TW-1:0]                   res_resp_reg, res_resp_next;
    logic [TW-1:0]                   res_tat_reg, res_tat_next;
    logic [TW-1:0]                   res_wait_reg, res_wait_next;
    logic [VW-1:0]                   res_burst_reg, res_burst_next;

    lrtf_pkg::slot_tok_t             tok_chain [0:MAX_PROCESSES];
    logic [IDW-1:0]                  id_chain  [0:MAX_PROCESSES];
    lrtf_pkg::slot_wr_t              wr;
    lrtf_pkg::slot_upd_t             upd;
    lrtf_pkg::slot_tok_t             best;
    logic [IDW-1:0]                  best_id;
    logic                            accept;
    logic [lrtf_pkg::CMD_W-1:0]      cmd;
    logic [VW-1:0]                   in_arr;
    logic [VW-1:0]                   in_burst;
    logic [TW-1:0]                   t_adv;
    logic [TW-1:0]                   fs_eff;
    logic [TW-1:0]                   arr_ext;
    logic [TW-1:0]                   burst_ext;

    assign tok_chain[0] = '0;
    assign id_chain[0]  = '0;

    for (genvar g = 0; g < MAX_PROCESSES; g++)
    begin : g_cell
        lrtf_cell #(
            .NUM_SLOTS (MAX_PROCESSES),
            .CELL_ID   (g)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .count    (count_reg),
            .cur_time (time_reg),
            .wr       (wr),
            .wr_id    (count_reg[IDW-1:0]),
            .upd      (upd),
            .upd_id   (best_id),
            .tok_in   (tok_chain[g]),
            .id_in    (id_chain[g]),
            .tok_out  (tok_chain[g+1]),
            .id_out   (id_chain[g+1])
        );
    end

    assign best     = tok_chain[MAX_PROCESSES];
    assign best_id  = id_chain[MAX_PROCESSES];
    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign cmd      = s_tuser;
    assign in_arr   = s_tdata[15:0];
    assign in_burst = s_tdata[31:16];
    assign t_adv    = (time_reg == lrtf_pkg::TIME_MAX) ? time_reg : time_reg + TW'(1);
    assign arr_ext  = {{(TW-VW){1'b0}}, best.arr};
    assign burst_ext = {{(TW-VW){1'b0}}, res_burst_reg};
    assign fs_eff   = (best.rem == best.burst) ? time_reg : best.fs;

    always_comb
    begin
        wr.en    = accept && (cmd == lrtf_pkg::CMD_ADD) && (in_burst != '0)
                   && (count_reg != CW'(MAX_PROCESSES));
        wr.arr   = in_arr;
        wr.burst = in_burst;
        upd.en    = (state_reg == S_SERVE) && best.found;
        upd.first = (best.rem == best.burst);
        upd.t     = time_reg;
    end

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        time_next       = time_reg;
        cnt_next        = cnt_reg;
        m_valid_next    = m_valid_reg;
        m_user_next     = m_user_reg;
        m_data_next     = m_data_reg;
        res_status_next = res_status_reg;
        res_id_next     = res_id_reg;
        res_comp_next   = res_comp_reg;
        res_resp_next   = res_resp_reg;
        res_tat_next    = res_tat_reg;
        res_wait_next   = res_wait_reg;
        res_burst_next  = res_burst_reg;

        if (m_valid_reg && m_tready)
        begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    res_id_next   = '0;
                    res_comp_next = '0;
                    res_resp_next = '0;
                    res_tat_next  = '0;
                    res_wait_next = '0;
                    state_next    = S_DELIVER;
                    case (cmd)
                        lrtf_pkg::CMD_ADD:
                        begin
                            if (wr.en)
                            begin
                                res_status_next = lrtf_pkg::ST_ADDED;
                                res_id_next     = lrtf_pkg::PID_W'(count_reg);
                                count_next      = count_reg + CW'(1);
                            end
                            else
                            begin
                                res_status_next = lrtf_pkg::ST_REJECTED;
                            end
                        end
                        lrtf_pkg::CMD_TICK:
                        begin
                            cnt_next   = '0;
                            state_next = S_SCAN;
                        end
                        lrtf_pkg::CMD_CLEAR:
                        begin
                            res_status_next = lrtf_pkg::ST_CLEARED;
                            count_next      = '0;
                            time_next       = '0;
                        end
                        default:
                        begin
                            res_status_next = lrtf_pkg::ST_REJECTED;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                cnt_next = cnt_reg + IDW'(1);
                if (cnt_reg == IDW'(MAX_PROCESSES - 1))
                begin
                    state_next = S_SERVE;
                end
            end
            S_SERVE:
            begin
                time_next   = t_adv;
                res_id_next = lrtf_pkg::PID_W'(best_id);
                state_next  = S_DELIVER;
                if (!best.found)
                begin
                    res_status_next = lrtf_pkg::ST_IDLE;
                    res_id_next     = '0;
                end
                else if (best.rem != VW'(1))
                begin
                    res_status_next = lrtf_pkg::ST_RAN;
                end
                else
                begin
                    res_status_next = lrtf_pkg::ST_FINISHED;
                    res_comp_next   = t_adv;
                    res_resp_next   = (fs_eff >= arr_ext) ? fs_eff - arr_ext : '0;
                    res_tat_next    = (t_adv >= arr_ext) ? t_adv - arr_ext : '0;
                    res_burst_next  = best.burst;
                    state_next      = S_WAIT;
                end
            end
            S_WAIT:
            begin
                res_wait_next = (res_tat_reg >= burst_ext) ? res_tat_reg - burst_ext : '0;
                state_next    = S_DELIVER;
            end
            S_DELIVER:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    m_valid_next = 1'b1;
                    m_user_next  = res_status_reg;
                    m_data_next  = {4'b0, res_wait_reg, res_tat_reg, res_resp_reg,
                                    res_comp_reg, res_id_reg};
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            time_reg       <= '0;
            cnt_reg        <= '0;
            m_valid_reg    <= 1'b0;
            m_user_reg     <= '0;
            m_data_reg     <= '0;
            res_status_reg <= '0;
            res_id_reg     <= '0;
            res_comp_reg   <= '0;
            res_resp_reg   <= '0;
            res_tat_reg    <= '0;
            res_wait_reg   <= '0;
            res_burst_reg  <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            time_reg       <= time_next;
            cnt_reg        <= cnt_next;
            m_valid_reg    <= m_valid_next;
            m_user_reg     <= m_user_next;
            m_data_reg     <= m_data_next;
            res_status_reg <= res_status_next;
            res_id_reg     <= res_id_next;
            res_comp_reg   <= res_comp_next;
            res_resp_reg   <= res_resp_next;
            res_tat_reg    <= res_tat_next;
            res_wait_reg   <= res_wait_next;
            res_burst_reg  <= res_burst_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_user_reg;
    assign m_tdata  = m_data_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_PROCESSES))
        else $error("Process count exceeds the table size.");

    a_clear_resets: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (cmd == lrtf_pkg::CMD_CLEAR)) |=> (count_reg == '0) && (time_reg == '0))
        else $error("Clear request did not empty the table and time.");

    a_finish_comp: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser == lrtf_pkg::ST_FINISHED)) |-> (m_tdata[35:4] != '0))
        else $error("Finished process reported a zero completion time.");

    a_quiet_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && ((m_tuser == lrtf_pkg::ST_REJECTED) || (m_tuser == lrtf_pkg::ST_IDLE)
                      || (m_tuser == lrtf_pkg::ST_CLEARED))) |-> (m_tdata == '0))
        else $error("Non-service result carries a non-zero payload.");

    a_upd_found: assert property (@(posedge clk) disable iff (!rst_n)
        upd.en |-> (best.rem != '0) && (arr_ext <= time_reg))
        else $error("Service update chose a slot with no work left.");

endmodule

// ===== bench/testbench.sv =====
// Self-checking bench for the longest-remaining-time-first tick scheduler, driven as request streams.
// Predicts every result in its own scheduler copy and compares them field by field in order.
// Depends on lrtf_pkg and lrtf_tick_scheduler_top.
`timescale 1ns / 100ps

module testbench;

    localparam int MAX_PROCS      = 16;
    localparam int CYCLE_LIMIT    = 400000;
    localparam int RANDOM_TARGET  = 400;
    localparam int LONG_HOLD      = 300;
    localparam int HOLD_AFTER     = 150;

    typedef struct packed {
        logic [lrtf_pkg::CMD_W-1:0]   cmd;
        logic [lrtf_pkg::VALUE_W-1:0] arrival;
        logic [lrtf_pkg::VALUE_W-1:0] burst;
    } sched_request_t;

    typedef struct packed {
        logic [lrtf_pkg::STATUS_W-1:0] status;
        logic [lrtf_pkg::PID_W-1:0]    pid;
        logic [lrtf_pkg::TIME_W-1:0]   completion;
        logic [lrtf_pkg::TIME_W-1:0]   response;
        logic [lrtf_pkg::TIME_W-1:0]   turnaround;
        logic [lrtf_pkg::TIME_W-1:0]   waiting;
    } sched_result_t;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [lrtf_pkg::IN_W-1:0]      s_tdata = '0;
    logic [lrtf_pkg::CMD_W-1:0]     s_tuser = '0;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [lrtf_pkg::OUT_W-1:0]     m_tdata;
    logic [lrtf_pkg::STATUS_W-1:0]  m_tuser;

    sched_request_t request_queue[$];
    sched_result_t  pending_results[$];

    logic [lrtf_pkg::TIME_W-1:0]  sim_time = '0;
    int                           table_count = 0;
    logic [lrtf_pkg::VALUE_W-1:0] arr_tab[MAX_PROCS];
    logic [lrtf_pkg::VALUE_W-1:0] burst_tab[MAX_PROCS];
    logic [lrtf_pkg::VALUE_W-1:0] left_tab[MAX_PROCS];
    logic [lrtf_pkg::TIME_W-1:0]  first_run_tab[MAX_PROCS];

    int accepted_requests = 0;
    int result_count = 0;
    int finished_count = 0;
    int rejected_count = 0;
    int idle_count = 0;
    int mismatch_count = 0;
    int cycle_count = 0;
    int burst_left = 0;
    int gap_left = 0;
    int phase_left = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;

    lrtf_tick_scheduler_top #(
        .MAX_PROCESSES(MAX_PROCS)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser)
    );

    always #1 clk = ~clk;

    function automatic sched_result_t schedule_request(input sched_request_t req);
        sched_result_t               res;
        logic [lrtf_pkg::TIME_W-1:0] now;
        logic [lrtf_pkg::TIME_W-1:0] next_time;
        logic [lrtf_pkg::TIME_W-1:0] arr32;
        logic [lrtf_pkg::TIME_W-1:0] burst32;
        logic                        found;
        int                          best;
        res = '0;
        res.status = lrtf_pkg::ST_REJECTED;
        case (req.cmd)
            lrtf_pkg::CMD_ADD:
            begin
                if (req.burst != '0 && table_count < MAX_PROCS)
                begin
                    arr_tab[table_count] = req.arrival;
                    burst_tab[table_count] = req.burst;
                    left_tab[table_count] = req.burst;
                    first_run_tab[table_count] = '0;
                    res.status = lrtf_pkg::ST_ADDED;
                    res.pid = table_count[lrtf_pkg::PID_W-1:0];
                    table_count = table_count + 1;
                end
            end
            lrtf_pkg::CMD_CLEAR:
            begin
                table_count = 0;
                sim_time = '0;
                res.status = lrtf_pkg::ST_CLEARED;
            end
            lrtf_pkg::CMD_TICK:
            begin
                now = sim_time;
                found = 1'b0;
                best = 0;
                for (int i = 0; i < MAX_PROCS; i++)
                begin
                    if (i < table_count && arr_tab[i] <= now && left_tab[i] != '0)
                    begin
                        if (!found)
                        begin
                            best = i;
                            found = 1'b1;
                        end
                        else if (left_tab[i] > left_tab[best])
                            best = i;
                        else if (left_tab[i] == left_tab[best] && arr_tab[i] < arr_tab[best])
                            best = i;
                    end
                end
                next_time = (now == lrtf_pkg::TIME_MAX) ? now : now + 1;
                sim_time = next_time;
                if (!found)
                    res.status = lrtf_pkg::ST_IDLE;
                else
                begin
                    if (left_tab[best] == burst_tab[best])
                        first_run_tab[best] = now;
                    left_tab[best] = left_tab[best] - 1'b1;
                    res.pid = best[lrtf_pkg::PID_W-1:0];
                    if (left_tab[best] != '0)
                        res.status = lrtf_pkg::ST_RAN;
                    else
                    begin
                        arr32 = {16'd0, arr_tab[best]};
                        burst32 = {16'd0, burst_tab[best]};
                        res.status = lrtf_pkg::ST_FINISHED;
                        res.completion = next_time;
                        res.response = (first_run_tab[best] >= arr32) ?
                                       first_run_tab[best] - arr32 : '0;
                        res.turnaround = (next_time >= arr32) ? next_time - arr32 : '0;
                        res.waiting = (res.turnaround >= burst32) ?
                                      res.turnaround - burst32 : '0;
                    end
                end
            end
            default:
            begin
            end
        endcase
        return res;
    endfunction

    task automatic queue_request(input logic [lrtf_pkg::CMD_W-1:0] cmd,
                                 input logic [lrtf_pkg::VALUE_W-1:0] arrival,
                                 input logic [lrtf_pkg::VALUE_W-1:0] burst);
        sched_request_t req;
        req.cmd = cmd;
        req.arrival = arrival;
        req.burst = burst;
        request_queue.push_back(req);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            burst_left = 0;
            gap_left = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                pending_results.push_back(schedule_request(request_queue.pop_front()));
                accepted_requests <= accepted_requests + 1;
            end
            if (!s_tvalid || s_tready)
            begin
                if (gap_left > 0 || request_queue.size() == 0)
                begin
                    if (gap_left > 0)
                        gap_left--;
                    s_tvalid <= 1'b0;
                end
                else
                begin
                    s_tvalid <= 1'b1;
                    s_tdata <= {request_queue[0].burst, request_queue[0].arrival};
                    s_tuser <= request_queue[0].cmd;
                    if (burst_left > 0)
                        burst_left--;
                    else
                    begin
                        burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) :
                                                                   $urandom_range(1, 8);
                        gap_left = $urandom_range(1, 12);
                    end
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            phase_left = 0;
            hold_left = 0;
        end
        else if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else if (!hold_done && accepted_requests >= HOLD_AFTER)
        begin
            hold_done = 1'b1;
            hold_left = LONG_HOLD;
            m_tready <= 1'b0;
        end
        else if (phase_left > 0)
            phase_left--;
        else
        begin
            case ($urandom_range(0, 3))
                0:
                begin
                    m_tready <= 1'b0;
                    phase_left = $urandom_range(0, 7);
                end
                3:
                begin
                    m_tready <= 1'b1;
                    phase_left = $urandom_range(50, 150);
                end
                default:
                begin
                    m_tready <= 1'b1;
                    phase_left = $urandom_range(0, 9);
                end
            endcase
        end
    end

    always @(posedge clk)
    begin
        sched_result_t seen;
        sched_result_t wanted;
        if (rst_n && m_tvalid && m_tready)
        begin
            seen.status = m_tuser;
            seen.pid = m_tdata[3:0];
            seen.completion = m_tdata[35:4];
            seen.response = m_tdata[67:36];
            seen.turnaround = m_tdata[99:68];
            seen.waiting = m_tdata[131:100];
            result_count++;
            if (seen.status == lrtf_pkg::ST_FINISHED)
                finished_count++;
            if (seen.status == lrtf_pkg::ST_REJECTED)
                rejected_count++;
            if (seen.status == lrtf_pkg::ST_IDLE)
                idle_count++;
            if (pending_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("Result %0d arrived with no request outstanding: status %0d id %0d",
                             result_count, seen.status, seen.pid);
            end
            else
            begin
                wanted = pending_results.pop_front();
                if (seen !== wanted)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                    begin
                        $display("Result %0d mismatch: expected status %0d id %0d comp %0d",
                                 result_count, wanted.status, wanted.pid, wanted.completion);
                        $display("    resp %0d tat %0d wait %0d; got status %0d id %0d comp %0d",
                                 wanted.response, wanted.turnaround, wanted.waiting,
                                 seen.status, seen.pid, seen.completion);
                        $display("    resp %0d tat %0d wait %0d",
                                 seen.response, seen.turnaround, seen.waiting);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Run stopped after %0d cycles with %0d requests still queued.",
                     cycle_count, request_queue.size());
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin
        int random_items;
        int procs;
        int latest;
        int work;
        int ticks;
        logic [lrtf_pkg::VALUE_W-1:0] a;
        logic [lrtf_pkg::VALUE_W-1:0] b;
        for (int i = 0; i < MAX_PROCS; i++)
        begin
            arr_tab[i] = '0;
            burst_tab[i] = '0;
            left_tab[i] = '0;
            first_run_tab[i] = '0;
        end

        // An idle tick on an empty table, an unknown command and a zero burst come first.
        queue_request(lrtf_pkg::CMD_TICK, 16'h0000, 16'h0000);
        queue_request(2'd3, 16'hFFFF, 16'hFFFF);
        queue_request(lrtf_pkg::CMD_ADD, 16'hFFFF, 16'h0000);
        queue_request(lrtf_pkg::CMD_ADD, 16'h0000, 16'h0001);
        queue_request(lrtf_pkg::CMD_ADD, 16'hFFFF, 16'hFFFF);
        queue_request(lrtf_pkg::CMD_ADD, 16'h0002, 16'h0003);
        queue_request(lrtf_pkg::CMD_ADD, 16'h0001, 16'h0003);
        queue_request(lrtf_pkg::CMD_ADD, 16'h0000, 16'h0002);
        for (int i = 5; i < MAX_PROCS; i++)
            queue_request(lrtf_pkg::CMD_ADD, 16'($urandom_range(0, 3)),
                          16'($urandom_range(1, 2)));
        // The table is full now, so this request is turned away.
        queue_request(lrtf_pkg::CMD_ADD, 16'h0005, 16'h0005);
        for (int i = 0; i < 6; i++)
            queue_request(lrtf_pkg::CMD_TICK, 16'hFFFF, 16'hFFFF);
        queue_request(lrtf_pkg::CMD_CLEAR, 16'hFFFF, 16'hFFFF);

        random_items = 0;
        while (random_items < RANDOM_TARGET)
        begin
            if ($urandom_range(0, 6) == 0)
            begin
                b = ($urandom_range(0, 3) == 0) ? 16'h0000 : 16'($urandom);
                queue_request(2'($urandom_range(0, 3)), 16'($urandom), b);
                random_items++;
            end
            else
            begin
                procs = ($urandom_range(0, 7) == 0) ? $urandom_range(14, 18) :
                                                      $urandom_range(1, 6);
                if ($urandom_range(0, 7) != 0)
                begin
                    queue_request(lrtf_pkg::CMD_CLEAR, 16'($urandom), 16'($urandom));
                    random_items++;
                end
                latest = 0;
                work = 0;
                for (int k = 0; k < procs; k++)
                begin
                    a = 16'($urandom_range(0, 10));
                    b = 16'($urandom_range(1, 5));
                    if (k < MAX_PROCS)
                    begin
                        latest = (a > latest) ? a : latest;
                        work += b;
                    end
                    queue_request(lrtf_pkg::CMD_ADD, a, b);
                    random_items++;
                    if ($urandom_range(0, 9) == 0)
                    begin
                        queue_request(2'($urandom_range(0, 3)), 16'($urandom), 16'($urandom));
                        random_items++;
                    end
                end
                ticks = latest + work + $urandom_range(0, 3);
                if ($urandom_range(0, 6) == 0)
                    ticks = $urandom_range(0, ticks);
                for (int k = 0; k < ticks; k++)
                    queue_request(lrtf_pkg::CMD_TICK, 16'($urandom), 16'($urandom));
                random_items += ticks;
            end
        end

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        while (request_queue.size() != 0 || s_tvalid || pending_results.size() != 0)
            @(posedge clk);
        repeat (2 * MAX_PROCS + 8) @(posedge clk);

        $display("Checked %0d results for %0d requests: %0d processes finished, %0d idle ticks,",
                 result_count, accepted_requests, finished_count, idle_count);
        $display("%0d rejections and %0d mismatches, including one long output stall.",
                 rejected_count, mismatch_count);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
